// ===== hdl/knnsel_pkg.sv =====
// ----------------------------------------------------------------------------
// knnsel_pkg
// Shared constants, codes and controller/datapath interface types for the
// k-nearest-neighbour top-K selector.
// ----------------------------------------------------------------------------
package knnsel_pkg;

  localparam int COORD_FIELDS = 4;
  localparam int COORD_W      = 16;
  localparam int PIDX_W       = 16;
  localparam int DIST_W       = 34;
  localparam int FUNC_W       = 2;
  localparam int IN_DATA_W    = 80;
  localparam int OUT_DATA_W   = 56;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam int K_CFG_W    = 5;
  localparam int DIMS_CFG_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CAND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] REG_K      = 2'd0;
  localparam logic [1:0] REG_DIMS   = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic cap_query;
    logic cap_cand;
    logic sq_en;
    logic acc_en;
    logic decide;
    logic scan_clr;
    logic cnt_clr;
    logic cnt_inc;
    logic scan_rd;
    logic out_rd;
    logic out_load;
  } knnsel_cmd_t;

  typedef struct packed {
    logic dim_last;
    logic append_ok;
    logic replace_ok;
    logic lim_zero;
    logic scan_last;
    logic rd_last;
    logic out_free;
  } knnsel_sts_t;

endpackage

// ===== hdl/knnsel_ram.sv =====
// ----------------------------------------------------------------------------
// knnsel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knnsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/knnsel_ctrl.sv =====
// ----------------------------------------------------------------------------
// knnsel_ctrl
// Sequencer for the selector: accepts items, steps the distance unit,
// decides append or replace, runs the maximum rescan and the readout.
// ----------------------------------------------------------------------------
module knnsel_ctrl
  import knnsel_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [FUNC_W-1:0]  in_func,
  input  knnsel_sts_t        sts,
  output knnsel_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_ACC      = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SCAN_END = 3'd5;
  localparam logic [2:0] S_RD_ISSUE = 3'd6;
  localparam logic [2:0] S_RD_LOAD  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_func)
            FUNC_START: begin
              cmd.cap_query = 1'b1;
            end
            FUNC_CAND: begin
              cmd.cap_cand = 1'b1;
              state_nxt    = S_MUL;
            end
            FUNC_READ: begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_RD_ISSUE;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = sts.dim_last ? S_DECIDE : S_MUL;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (sts.append_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.replace_ok) begin
          cmd.scan_clr = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_nxt    = sts.lim_zero ? S_IDLE : S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_IDLE;
      end
      S_RD_ISSUE: begin
        cmd.out_rd = 1'b1;
        state_nxt  = S_RD_LOAD;
      end
      S_RD_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_RD_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/knnsel_dp.sv =====
// ----------------------------------------------------------------------------
// knnsel_dp
// Datapath: query and candidate registers, one squarer with accumulator,
// slot RAM, fill count, running maximum and the output register.
// ----------------------------------------------------------------------------
module knnsel_dp
  import knnsel_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  knnsel_cmd_t           cmd,
  output knnsel_sts_t           sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [K_CFG_W-1:0]    cfg_k,
  input  logic [DIMS_CFG_W-1:0] cfg_dims,
  input  logic [DIST_W-1:0]     cfg_radius,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int IDX_W   = (INDEX_BITS < PIDX_W) ? INDEX_BITS : PIDX_W;
  localparam int COORD_N = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;
  localparam int DW      = (COORD_N > 1) ? $clog2(COORD_N) : 1;
  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KW      = $clog2(SLOT_COUNT + 1);
  localparam int SQ_W    = 2 * COORD_W;
  localparam int OUT_PAD = OUT_DATA_W - PIDX_W - DIST_W;
  localparam int RAM_W   = IDX_W + DIST_W;

  logic [IDX_W-1:0]          query_id_r;
  logic signed [COORD_W-1:0] qc_r [COORD_N];
  logic [IDX_W-1:0]          cand_idx_r;
  logic signed [COORD_W-1:0] cc_r [COORD_N];
  logic [DW-1:0]             dim_r;
  logic [SQ_W-1:0]           sq_r;
  logic [DIST_W-1:0]         acc_r;
  logic [KW-1:0]             fill_r;
  logic [DIST_W-1:0]         max_r;
  logic [SLOT_AW-1:0]        max_slot_r;
  logic [SLOT_AW-1:0]        cnt_r;
  logic                      scan_vld_r;
  logic [SLOT_AW-1:0]        scan_slot_r;

  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic                      out_slot_r;
  logic                      out_last_r;

  logic [KW-1:0]             k_eff;
  logic [DIMS_CFG_W-1:0]     dims_eff;
  logic [KW-1:0]             lim;
  logic [DIST_W-1:0]         dist_c;
  logic signed [COORD_W:0]   diff;
  logic signed [SQ_W+1:0]    prod;
  logic                      append_ok;
  logic                      replace_ok;

  logic                      ram_we;
  logic [SLOT_AW-1:0]        ram_waddr;
  logic [RAM_W-1:0]          ram_rdata;
  logic [IDX_W-1:0]          rd_idx;
  logic [DIST_W-1:0]         rd_dist;

  always_comb begin
    priority if (cfg_k == '0) begin
      k_eff = KW'(1);
    end else if (int'(cfg_k) > SLOT_COUNT) begin
      k_eff = KW'(SLOT_COUNT);
    end else begin
      k_eff = KW'(cfg_k);
    end
    priority if (cfg_dims == '0) begin
      dims_eff = DIMS_CFG_W'(1);
    end else if (int'(cfg_dims) > COORD_N) begin
      dims_eff = DIMS_CFG_W'(COORD_N);
    end else begin
      dims_eff = cfg_dims;
    end
  end

  assign lim    = (fill_r < k_eff) ? fill_r : k_eff;
  assign dist_c = (cand_idx_r == query_id_r) ? '0 : acc_r;
  assign diff   = {qc_r[dim_r][COORD_W-1], qc_r[dim_r]} - {cc_r[dim_r][COORD_W-1], cc_r[dim_r]};
  assign prod   = diff * diff;

  assign append_ok  = (fill_r < k_eff) && ((cfg_radius == '0) || (dist_c <= cfg_radius));
  assign replace_ok = dist_c < max_r;

  assign sts.dim_last   = (DIMS_CFG_W'(dim_r) + DIMS_CFG_W'(1)) == dims_eff;
  assign sts.append_ok  = append_ok;
  assign sts.replace_ok = replace_ok;
  assign sts.lim_zero   = (lim == '0);
  assign sts.scan_last  = (KW'(cnt_r) + KW'(1)) == lim;
  assign sts.rd_last    = (KW'(cnt_r) + KW'(1)) == k_eff;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign ram_we    = cmd.decide && (append_ok || replace_ok);
  assign ram_waddr = append_ok ? fill_r[SLOT_AW-1:0] : max_slot_r;

  knnsel_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cand_idx_r, dist_c}),
    .re    (cmd.scan_rd || cmd.out_rd),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  assign rd_idx  = ram_rdata[RAM_W-1:DIST_W];
  assign rd_dist = ram_rdata[DIST_W-1:0];

  // query, candidate and distance unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_id_r <= '0;
      for (int i = 0; i < COORD_N; i++) begin
        qc_r[i] <= '0;
      end
      dim_r <= '0;
    end else begin
      if (cmd.cap_query) begin
        query_id_r <= in_tdata[IDX_W-1:0];
        for (int i = 0; i < COORD_N; i++) begin
          qc_r[i] <= in_tdata[PIDX_W + COORD_W*i +: COORD_W];
        end
      end
      if (cmd.cap_cand) begin
        dim_r <= '0;
      end else if (cmd.acc_en) begin
        dim_r <= dim_r + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cand) begin
      cand_idx_r <= in_tdata[IDX_W-1:0];
      for (int i = 0; i < COORD_N; i++) begin
        cc_r[i] <= in_tdata[PIDX_W + COORD_W*i +: COORD_W];
      end
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + DIST_W'(sq_r);
    end
    if (cmd.sq_en) begin
      sq_r <= prod[SQ_W-1:0];
    end
  end

  // list bookkeeping and maximum tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      max_r       <= '0;
      max_slot_r  <= '0;
      cnt_r       <= '0;
      scan_vld_r  <= 1'b0;
      scan_slot_r <= '0;
    end else begin
      scan_vld_r  <= cmd.scan_rd;
      scan_slot_r <= cnt_r;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + SLOT_AW'(1);
      end
      if (cmd.cap_query) begin
        fill_r     <= '0;
        max_r      <= '0;
        max_slot_r <= '0;
      end else if (cmd.decide && append_ok) begin
        fill_r <= fill_r + KW'(1);
        if (dist_c > max_r) begin
          max_r      <= dist_c;
          max_slot_r <= fill_r[SLOT_AW-1:0];
        end
      end else if (cmd.scan_clr) begin
        max_r      <= '0;
        max_slot_r <= '0;
      end else if (scan_vld_r && (rd_dist > max_r)) begin
        max_r      <= rd_dist;
        max_slot_r <= scan_slot_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot_r <= KW'(cnt_r) < fill_r;
      out_idx_r  <= (KW'(cnt_r) < fill_r) ? rd_idx : '0;
      out_dist_r <= (KW'(cnt_r) < fill_r) ? rd_dist : '0;
      out_last_r <= sts.rd_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_dist_r, PIDX_W'(out_idx_r)};
  assign out_tuser  = out_slot_r;
  assign out_tlast  = out_last_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= KW'(SLOT_COUNT))
    else $error("fill count above slot count");

  a_max_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (max_r != '0) |-> (KW'(max_slot_r) < fill_r))
    else $error("maximum points at an unfilled slot");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decide && append_ok) |=> (fill_r == $past(fill_r) + KW'(1)))
    else $error("append did not advance fill count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten before transfer");

endmodule

// ===== hdl/knn_top_k_selector.sv =====
// ----------------------------------------------------------------------------
// knn_top_k_selector
// Keeps the K nearest candidates of one query by squared Euclidean distance.
// ----------------------------------------------------------------------------
// One item is processed at a time; in_tready is high only between items.
// A start item is taken in the idle state. A candidate passes a multiply
// and an accumulate state per dimension in use, set by the single shared
// squarer and its accumulator, then a decide state; a replace of the
// maximum adds a rescan of L = min(fill count, K) slots, one read a cycle
// on the RAM read port. A readout issues a RAM read and loads the output
// register per transfer, waiting on output stalls; the last transfer may
// wait there while the next item is taken. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module knn_top_k_selector
  import knnsel_pkg::*;
#(
  parameter int SLOT_COUNT = 16,
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // point_index, coord_0, coord_1, coord_2, coord_3
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // neighbour_index, neighbour_distance, pad
  output logic                  out_tuser,  // slot_valid
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [K_CFG_W-1:0]    k_cfg_r;
  logic [DIMS_CFG_W-1:0] dims_cfg_r;
  logic [DIST_W-1:0]     radius_r;
  logic                  cfg_wr;
  logic [1:0]            cfg_sel;
  knnsel_cmd_t           cmd;
  knnsel_sts_t           sts;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_cfg_r    <= K_CFG_W'(16);
      dims_cfg_r <= DIMS_CFG_W'(4);
      radius_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_K:      k_cfg_r    <= cfg_pwdata[K_CFG_W-1:0];
        REG_DIMS:   dims_cfg_r <= cfg_pwdata[DIMS_CFG_W-1:0];
        REG_RADIUS: radius_r   <= cfg_pwdata[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_K:      cfg_prdata = CFG_DW'(k_cfg_r);
      REG_DIMS:   cfg_prdata = CFG_DW'(dims_cfg_r);
      REG_RADIUS: cfg_prdata = CFG_DW'(radius_r);
      default:    cfg_prdata = '0;
    endcase
  end

  knnsel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  knnsel_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_k      (k_cfg_r),
    .cfg_dims   (dims_cfg_r),
    .cfg_radius (radius_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/knn_top_k_selector_tb.sv =====
// ----------------------------------------------------------------------------
// knn_top_k_selector_tb
// Self-checking bench for the top-K nearest neighbour selector. Queries,
// candidates and readouts are streamed in with bursty pacing while the result
// side stalls on its own pattern. A bit-accurate copy of the list update runs
// on every accepted input transfer, and each readout slot is checked field by
// field against it. Directed queries hit the range clamps, radius limit,
// replacement order and K changes mid-query; random queries follow.
// ----------------------------------------------------------------------------
module knn_top_k_selector_tb;
  import knnsel_pkg::*;

  localparam int                SLOTS       = 16;
  localparam int                DIMS        = 4;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam longint            DIST_MAX    = 64'h3_FFFF_FFFF;

  typedef logic [COORD_FIELDS-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct {
    logic [PIDX_W-1:0] index;
    logic [DIST_W-1:0] distance;
    logic              valid;
    logic              last;
  } slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  knn_top_k_selector uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // shadow of the selector state
  logic [K_CFG_W-1:0]    k_reg = 5'd16;
  logic [DIMS_CFG_W-1:0] dims_reg = 3'd4;
  logic [DIST_W-1:0]     radius_reg = '0;
  logic [PIDX_W-1:0]     q_id = '0;
  coord_vec_t            q_coord = '0;
  logic [PIDX_W-1:0]     s_idx [SLOTS];
  logic [DIST_W-1:0]     s_dist [SLOTS];
  int                    fill_cnt = 0;
  logic [DIST_W-1:0]     max_dist = '0;
  int                    max_slot = 0;

  slot_t expected_slots[$];
  slot_t want;
  int    mismatches = 0;
  int    burst_left = 0;
  int    rx_mode = 0;
  int    rx_left = 0;
  int    rx_tick = 0;

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    if (k_reg > SLOTS) return SLOTS;
    return int'(k_reg);
  endfunction

  function automatic int eff_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > DIMS) return DIMS;
    return int'(dims_reg);
  endfunction

  function automatic coord_vec_t coords4(input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [15:0] c2, input logic [15:0] c3);
    return {c3, c2, c1, c0};
  endfunction

  task automatic track_item(input logic [FUNC_W-1:0] func, input logic [PIDX_W-1:0] idx,
                            input coord_vec_t c);
    longint            diff;
    longint            sum;
    logic [DIST_W-1:0] cand_dist;
    int                kk;
    int                lim;
    slot_t             s;
    kk = eff_k();
    case (func)
      FUNC_START: begin
        q_id     = idx;
        q_coord  = c;
        fill_cnt = 0;
        max_dist = '0;
        max_slot = 0;
      end
      FUNC_CAND: begin
        sum = 0;
        if (idx != q_id) begin
          for (int d = 0; d < eff_dims(); d++) begin
            diff = longint'(signed'(q_coord[d])) - longint'(signed'(c[d]));
            sum += diff * diff;
          end
          if (sum > DIST_MAX) sum = DIST_MAX;
        end
        cand_dist = sum[DIST_W-1:0];
        if (fill_cnt < kk && (radius_reg == 0 || cand_dist <= radius_reg)) begin
          s_idx[fill_cnt]  = idx;
          s_dist[fill_cnt] = cand_dist;
          if (cand_dist > max_dist) begin
            max_dist = cand_dist;
            max_slot = fill_cnt;
          end
          fill_cnt++;
        end else if (cand_dist < max_dist) begin
          s_idx[max_slot]  = idx;
          s_dist[max_slot] = cand_dist;
          lim      = (fill_cnt < kk) ? fill_cnt : kk;
          max_dist = '0;
          max_slot = 0;
          for (int n = 0; n < lim; n++) begin
            if (s_dist[n] > max_dist) begin
              max_dist = s_dist[n];
              max_slot = n;
            end
          end
        end
      end
      FUNC_READ: begin
        for (int n = 0; n < kk; n++) begin
          s.valid    = (n < fill_cnt);
          s.index    = s.valid ? s_idx[n] : '0;
          s.distance = s.valid ? s_dist[n] : '0;
          s.last     = (n == kk - 1);
          expected_slots.push_back(s);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [PIDX_W-1:0] idx,
                           input coord_vec_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {c, idx};
    do @(posedge clk); while (!in_tready);
    track_item(func, idx, c);
  endtask

  // drop valid and let the block drain, including candidates still in flight
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] reg_id, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_id, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (reg_id)
      REG_K:      k_reg = value[K_CFG_W-1:0];
      REG_DIMS:   dims_reg = value[DIMS_CFG_W-1:0];
      REG_RADIUS: radius_reg = value[DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [K_CFG_W-1:0] k, input logic [DIMS_CFG_W-1:0] dims,
                           input logic [DIST_W-1:0] radius);
    settle();
    write_reg(REG_K, CFG_DW'(k));
    write_reg(REG_DIMS, CFG_DW'(dims));
    write_reg(REG_RADIUS, CFG_DW'(radius));
  endtask

  // candidate before any start is judged against the reset query
  task automatic test_power_on();
    send_item(FUNC_CAND, 16'd0, coords4(16'h1234, 16'h8001, 16'h7FFE, 16'hABCD));
    send_item(FUNC_READ, 16'd0, '0);
  endtask

  task automatic test_field_extremes();
    configure(5'd16, 3'd4, '0);
    send_item(FUNC_START, 16'h8000, coords4(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(FUNC_CAND, 16'h7FFF, coords4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_UNUSED, 16'hFFFF, '1);
    send_item(FUNC_CAND, 16'h8000, coords4(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_READ, 16'hFFFF, '1);
  endtask

  task automatic test_register_clamps();
    configure(5'd0, 3'd0, '0);
    send_item(FUNC_START, 16'd10, '0);
    send_item(FUNC_CAND, 16'd11, coords4(16'd3, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_item(FUNC_CAND, 16'd12, coords4(16'd1, 16'h8000, 16'h7FFF, 16'h8000));
    send_item(FUNC_READ, 16'd0, '0);
    configure(5'd31, 3'd7, 34'h3_FFFF_FFFF);
    send_item(FUNC_READ, 16'd0, '0);
  endtask

  // equal distance must not replace; first-wins on tied maximum
  task automatic test_radius_and_replace();
    configure(5'd3, 3'd2, 34'd100);
    send_item(FUNC_START, 16'd1, '0);
    send_item(FUNC_CAND, 16'd2, coords4(16'd10, 16'd0, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd3, coords4(16'd11, 16'd0, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd4, coords4(16'd5, 16'd0, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd5, coords4(16'd3, 16'd4, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd6, coords4(16'd0, 16'd10, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd7, coords4(16'd4, 16'd0, 16'd0, 16'd99));
    send_item(FUNC_READ, 16'd0, '0);
  endtask

  task automatic test_zero_distances();
    coord_vec_t q;
    q = coords4(16'd100, -16'sd200, 16'd300, -16'sd400);
    configure(5'd1, 3'd4, '0);
    send_item(FUNC_START, 16'd20, q);
    send_item(FUNC_CAND, 16'd21, q);
    send_item(FUNC_CAND, 16'd20, coords4(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_item(FUNC_READ, 16'd0, '0);
  endtask

  task automatic test_k_change_mid_query();
    configure(5'd3, 3'd1, '0);
    send_item(FUNC_START, 16'd30, '0);
    send_item(FUNC_CAND, 16'd31, coords4(16'd1, 16'd0, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd32, coords4(16'd2, 16'd0, 16'd0, 16'd0));
    send_item(FUNC_CAND, 16'd33, coords4(16'd3, 16'd0, 16'd0, 16'd0));
    configure(5'd2, 3'd1, '0);
    send_item(FUNC_CAND, 16'd34, coords4(16'd0, 16'd5, 16'd0, 16'd0));
    send_item(FUNC_READ, 16'd0, '0);
    configure(5'd3, 3'd1, '0);
    send_item(FUNC_READ, 16'd0, '0);
  endtask

  task automatic test_random_queries();
    int                    sent;
    int                    n_cand;
    int                    r;
    logic [K_CFG_W-1:0]    k_new;
    logic [DIST_W-1:0]     rad;
    logic [PIDX_W-1:0]     idx;
    coord_vec_t            qc;
    coord_vec_t            c;
    sent = 0;
    while (sent < 360) begin
      if (sent == 0 || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 6) k_new = 5'($urandom_range(1, 4));
        else if (r < 8) k_new = 5'($urandom_range(5, 16));
        else if (r == 8) k_new = '0;
        else k_new = 5'($urandom_range(17, 31));
        case ($urandom_range(0, 4))
          0, 1:    rad = '0;
          2:       rad = 34'($urandom_range(1, 200000));
          3:       rad = {2'($urandom_range(0, 3)), $urandom};
          default: rad = '1;
        endcase
        configure(k_new, 3'($urandom_range(0, 7)), rad);
      end
      for (int d = 0; d < COORD_FIELDS; d++)
        qc[d] = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 512)) - 16'd256;
      send_item(FUNC_START, 16'($urandom), qc);
      sent++;
      n_cand = $urandom_range(0, 2 * eff_k() + 3);
      for (int i = 0; i < n_cand; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_item(FUNC_UNUSED, 16'($urandom), {$urandom, $urandom});
        end else if (r == 1) begin
          send_item(FUNC_READ, 16'($urandom), {$urandom, $urandom});
          sent++;
        end else begin
          idx = ($urandom_range(0, 9) == 0) ? q_id : 16'($urandom);
          for (int d = 0; d < COORD_FIELDS; d++) begin
            case ($urandom_range(0, 3))
              0:       c[d] = q_coord[d];
              1:       c[d] = q_coord[d] + 16'($urandom_range(0, 16)) - 16'd8;
              2:       c[d] = q_coord[d] + 16'($urandom_range(0, 1024)) - 16'd512;
              default: c[d] = 16'($urandom);
            endcase
          end
          send_item(FUNC_CAND, idx, c);
          sent++;
        end
      end
      if ($urandom_range(0, 7) != 0) begin
        send_item(FUNC_READ, 16'($urandom), {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_tick % 8) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_slots.size() == 0) begin
        $error("result transfer with nothing expected: index %0d", out_tdata[15:0]);
        mismatches++;
      end else begin
        want = expected_slots.pop_front();
        if (out_tdata[15:0] !== want.index) begin
          $error("neighbour_index: expected %0d, got %0d", want.index, out_tdata[15:0]);
          mismatches++;
        end
        if (out_tdata[49:16] !== want.distance) begin
          $error("neighbour_distance: expected %0d, got %0d", want.distance, out_tdata[49:16]);
          mismatches++;
        end
        if (out_tuser !== want.valid) begin
          $error("slot_valid: expected %0b, got %0b", want.valid, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_power_on();
    test_field_extremes();
    test_register_clamps();
    test_radius_and_replace();
    test_zero_distances();
    test_k_change_mid_query();
    test_random_queries();
    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/knnsel_pkg.sv
hdl/knnsel_ram.sv
hdl/knnsel_ctrl.sv
hdl/knnsel_dp.sv
hdl/knn_top_k_selector.sv
tb/knn_top_k_selector_tb.sv
